>>> rtl/sui_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sui_pkg
// Word types and status codes shared by the sorted unique insert block.
// ----------------------------------------------------------------------------
package sui_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_DUPLICATE = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_CLEARED   = 2'd3;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] value;
	} req_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] position;
		logic [4:0] stored_count;
	} rsp_word_t;

	typedef struct packed {
		logic ins;
		logic valid;
	} cell_ctl_t;

	typedef struct packed {
		logic ge;
		logic hit;
	} cell_stat_t;

endpackage

>>> rtl/sorted_unique_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_insert
// Ordered store of distinct signed values built as a row of compare and
// shift cells.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH distinct signed 32-bit values in ascending
// order. Each request word either inserts a value or clears the store, and
// yields exactly one response word: inserted with the slot used, duplicate,
// full, or cleared, together with the count held afterwards. Every cell of
// the row compares its entry with the key and shifts in the same cycle, so
// one word is taken per clock unless an unconsumed response stalls input;
// the response comes from an output register in the cycle after acceptance,
// and a new request is taken while it waits if it is consumed in the same cycle.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_unique_insert
	import sui_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp_word
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CW-1:0]      count_q;
	logic               rsp_valid_q;
	rsp_word_t          rsp_q;

	cell_ctl_t          ctl [DEPTH];
	cell_stat_t         stat [DEPTH];
	logic signed [31:0] entry [DEPTH];
	logic [DEPTH-1:0]   ge;
	logic [DEPTH-1:0]   hit;
	logic [DEPTH-1:0]   bound;

	logic               accept;
	logic               dup;
	logic               full;
	logic               ins_do;
	logic [PW-1:0]      pos;
	logic [CW-1:0]      count_next;
	logic [PW+3:0]      pos_ext;
	logic [CW+4:0]      count_ext;

	assign accept    = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctl[i].ins   = ins_do;
		assign ctl[i].valid = CW'(i) < count_q;
		assign ge[i]        = stat[i].ge;
		assign hit[i]       = stat[i].hit;
		if (i == 0) begin : g_first
			assign bound[i] = ge[i];
			sui_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[i]),
				.key        (req_word.value),
				.prev_ge    (1'b0),
				.prev_entry (req_word.value),
				.stat       (stat[i]),
				.entry      (entry[i])
			);
		end else begin : g_next
			assign bound[i] = ge[i] && !ge[i-1];
			sui_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[i]),
				.key        (req_word.value),
				.prev_ge    (ge[i-1]),
				.prev_entry (entry[i-1]),
				.stat       (stat[i]),
				.entry      (entry[i])
			);
		end
	end

	assign dup    = |hit;
	assign full   = count_q == CW'(DEPTH);
	assign ins_do = accept && (req_word.operation == OP_INSERT) && !dup && !full;

	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (bound[i]) begin
				pos = pos | PW'(i);
			end
		end
	end

	always_comb begin
		if (req_word.operation == OP_CLEAR) begin
			count_next = '0;
		end else if (ins_do) begin
			count_next = count_q + CW'(1);
		end else begin
			count_next = count_q;
		end
	end

	assign pos_ext   = {4'b0, pos};
	assign count_ext = {5'b0, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.stored_count <= count_ext[4:0];
			rsp_q.position     <= ins_do ? pos_ext[3:0] : 4'd0;
			if (req_word.operation == OP_CLEAR) begin
				rsp_q.status <= ST_CLEARED;
			end else if (dup) begin
				rsp_q.status <= ST_DUPLICATE;
			end else if (full) begin
				rsp_q.status <= ST_FULL;
			end else begin
				rsp_q.status <= ST_INSERTED;
			end
		end
	end

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_one_boundary : assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bound))
		else $error("row lost its ascending order");

	a_clear_empties : assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_word.operation == OP_CLEAR) |=> count_q == '0)
		else $error("clear left entries");

	a_insert_grows : assert property (@(posedge clk) disable iff (!arst_n)
		ins_do |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not advance count");

endmodule

>>> rtl/sui_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sui_cell
// One slot of the sorted row: compares its entry with the key, and on an
// insert at or past the insertion point takes the key or the entry of its lower neighbor.
// ----------------------------------------------------------------------------
module sui_cell
	import sui_pkg::*;
(
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic signed [31:0] key,
	input  logic               prev_ge,
	input  logic signed [31:0] prev_entry,
	output cell_stat_t         stat,
	output logic signed [31:0] entry
);

	logic signed [31:0] entry_q;

	assign stat.ge  = !(ctl.valid && (entry_q < key));
	assign stat.hit = ctl.valid && (entry_q == key);
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && stat.ge) begin
			if (prev_ge) begin
				entry_q <= prev_entry;
			end else begin
				entry_q <= key;
			end
		end
	end

endmodule
